// File: rtl/cfl_pkg.sv
`timescale 1ns / 1ps

package cfl_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;

    // datapath widths
    localparam int V_W    = 32 + FRAC_BITS;      // velocity magnitude
    localparam int SPD_W  = V_W + 1;             // |v| + c
    localparam int P_W    = 51 - FRAC_BITS;      // pressure
    localparam int ROOT_W = 35;                  // speed of sound
    localparam int A_W    = 2 * ROOT_W;          // operand a of the shared unit
    localparam int B_W    = 33;                  // operand b of the shared unit
    localparam int PR_W   = SPD_W + 32;          // product / result width
    localparam int CNT_W  = 7;

    localparam logic [18:0] GAMMA_ONE   = 19'(1 << FRAC_BITS);
    localparam logic [18:0] GAMMA_RESET = 19'd91750;

    // configuration register indexes
    localparam logic REG_GAMMA = 1'b0;
    localparam logic REG_DT    = 1'b1;

    // shared unit operations
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    // one classified grid point
    typedef struct packed {
        logic [31:0] rho;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] energy;
        logic [31:0] inv_dx;
        logic [31:0] inv_dy;
        logic        last;
    } point_t;

    typedef struct packed {
        logic            start;
        logic [1:0]      op;
        logic [A_W-1:0]  a;
        logic [B_W-1:0]  b;
    } ar_req_t;

    typedef struct packed {
        logic             done;
        logic [PR_W-1:0]  res;
    } ar_resp_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

endpackage

// File: rtl/cfl_front.sv
`timescale 1ns / 1ps

module cfl_front
    import cfl_pkg::*;
(
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    input  q_stat_t      q_stat,
    output logic         push,
    output point_t       pt
);

    logic [31:0] mx_raw;
    logic [31:0] my_raw;

    // accept whenever the queue has room
    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && !q_stat.full;

    assign mx_raw = s_axis_tdata[63:32];
    assign my_raw = s_axis_tdata[95:64];

    // zero density becomes one lsb, momenta become magnitudes
    always_comb
    begin
        pt.rho    = (s_axis_tdata[31:0] == 32'd0) ? 32'd1 : s_axis_tdata[31:0];
        pt.mx     = mx_raw[31] ? (32'd0 - mx_raw) : mx_raw;
        pt.my     = my_raw[31] ? (32'd0 - my_raw) : my_raw;
        pt.energy = s_axis_tdata[127:96];
        pt.inv_dx = s_axis_tdata[159:128];
        pt.inv_dy = s_axis_tdata[191:160];
        pt.last   = s_axis_tlast;
    end

endmodule

// File: rtl/cfl_queue.sv
`timescale 1ns / 1ps

module cfl_queue
    import cfl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  point_t  wr_data,
    input  logic    pop,
    output point_t  rd_data,
    output q_stat_t q_stat
);

    point_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.valid = (count_reg != 2'd0);

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/cfl_arith.sv
`timescale 1ns / 1ps

module cfl_arith
    import cfl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ar_req_t  req,
    output ar_resp_t resp
);

    logic              busy_reg;
    logic              done_reg;
    logic [1:0]        op_reg;
    logic [CNT_W-1:0]  cnt_reg;
    // multiply
    logic [PR_W-1:0]   acc_reg;
    logic [PR_W-1:0]   mca_reg;
    logic [31:0]       mb_reg;
    // divide
    logic [63:0]       dq_reg;
    logic [32:0]       rem_reg;
    logic [32:0]       div_reg;
    // square root
    logic [A_W-1:0]    rad_reg;
    logic [ROOT_W+2:0] srem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [33:0]       dshift;
    logic [33:0]       ddiff;
    logic              dge;
    logic [ROOT_W+2:0] sshift;
    logic [ROOT_W+2:0] strial;
    logic              sge;

    // one step of each iteration
    always_comb
    begin
        dshift = {rem_reg, dq_reg[63]};
        ddiff  = dshift - {1'b0, div_reg};
        dge    = (dshift >= {1'b0, div_reg});
        sshift = {srem_reg[ROOT_W:0], rad_reg[A_W-1 -: 2]};
        strial = {1'b0, root_reg, 2'b01};
        sge    = (sshift >= strial);
    end

    // result select
    always_comb
    begin
        resp.done = done_reg;
        case (op_reg)
            OP_MUL:  resp.res = acc_reg;
            OP_DIV:  resp.res = PR_W'(dq_reg);
            OP_SQRT: resp.res = PR_W'(root_reg);
            default: resp.res = '0;
        endcase
    end

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                case (req.op)
                    OP_MUL:  cnt_reg <= CNT_W'(32);
                    OP_DIV:  cnt_reg <= CNT_W'(64);
                    OP_SQRT: cnt_reg <= CNT_W'(ROOT_W);
                    default: cnt_reg <= CNT_W'(1);
                endcase
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg  <= '0;
            mca_reg  <= PR_W'(req.a[SPD_W-1:0]);
            mb_reg   <= req.b[31:0];
            dq_reg   <= req.a[63:0];
            rem_reg  <= '0;
            div_reg  <= req.b;
            rad_reg  <= req.a;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    if (mb_reg[0])
                    begin
                        acc_reg <= acc_reg + mca_reg;
                    end
                    mca_reg <= mca_reg << 1;
                    mb_reg  <= mb_reg >> 1;
                end
                OP_DIV:
                begin
                    rem_reg <= dge ? ddiff[32:0] : dshift[32:0];
                    dq_reg  <= {dq_reg[62:0], dge};
                end
                OP_SQRT:
                begin
                    srem_reg <= sge ? (sshift - strial) : sshift;
                    root_reg <= {root_reg[ROOT_W-2:0], sge};
                    rad_reg  <= rad_reg << 2;
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

endmodule

// File: rtl/cfl_back.sv
`timescale 1ns / 1ps

module cfl_back
    import cfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     q_stat,
    input  point_t      q_data,
    output logic        pop,
    input  logic [18:0] gamma,
    input  logic [31:0] time_step,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tuser
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_VX   = 4'd1;
    localparam logic [3:0] ST_VY   = 4'd2;
    localparam logic [3:0] ST_MX2  = 4'd3;
    localparam logic [3:0] ST_MY2  = 4'd4;
    localparam logic [3:0] ST_KE   = 4'd5;
    localparam logic [3:0] ST_P    = 4'd6;
    localparam logic [3:0] ST_GP   = 4'd7;
    localparam logic [3:0] ST_C2   = 4'd8;
    localparam logic [3:0] ST_SQ   = 4'd9;
    localparam logic [3:0] ST_SX   = 4'd10;
    localparam logic [3:0] ST_CX   = 4'd11;
    localparam logic [3:0] ST_SY   = 4'd12;
    localparam logic [3:0] ST_CY   = 4'd13;
    localparam logic [3:0] ST_DONE = 4'd14;

    logic [3:0]        step_reg;
    logic              launched_reg;
    point_t            pt_reg;
    logic [V_W-1:0]    vx_reg;
    logic [V_W-1:0]    vy_reg;
    logic [63:0]       acc_reg;
    logic [P_W-1:0]    p_reg;
    logic [ROOT_W-1:0] c_reg;
    logic [SPD_W-1:0]  t_reg;
    logic [31:0]       max_reg;
    logic              flag_reg;
    logic              out_valid_reg;
    logic [31:0]       out_max_reg;
    logic              out_flag_reg;

    ar_req_t           req;
    ar_resp_t          resp;
    logic              compute;
    logic              good;
    logic [P_W-1:0]    p_now;
    logic [31:0]       cfl_now;
    logic              emit;

    cfl_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .resp  (resp)
    );

    assign pop           = (step_reg == ST_IDLE) && q_stat.valid;
    assign compute       = (step_reg != ST_IDLE) && (step_reg != ST_DONE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_max_reg;
    assign m_axis_tuser  = out_flag_reg;

    // sweep result moves into the output register
    assign emit = (step_reg == ST_DONE) && pt_reg.last && (!out_valid_reg || m_axis_tready);

    // decisions on the unit result
    always_comb
    begin
        good    = (64'(pt_reg.energy) > resp.res[63:0]) && (gamma > GAMMA_ONE);
        p_now   = resp.res[P_W+FRAC_BITS-1:FRAC_BITS];
        cfl_now = (|resp.res[PR_W-1:32+FRAC_BITS]) ? 32'hFFFF_FFFF
                                                   : resp.res[31+FRAC_BITS:FRAC_BITS];
    end

    // operand select per step
    always_comb
    begin
        req.start = compute && !launched_reg;
        req.op    = OP_MUL;
        req.a     = '0;
        req.b     = '0;
        case (step_reg)
            ST_VX:
            begin
                req.op = OP_DIV;
                req.a  = A_W'(pt_reg.mx) << FRAC_BITS;
                req.b  = B_W'(pt_reg.rho);
            end
            ST_VY:
            begin
                req.op = OP_DIV;
                req.a  = A_W'(pt_reg.my) << FRAC_BITS;
                req.b  = B_W'(pt_reg.rho);
            end
            ST_MX2:
            begin
                req.a = A_W'(pt_reg.mx);
                req.b = B_W'(pt_reg.mx);
            end
            ST_MY2:
            begin
                req.a = A_W'(pt_reg.my);
                req.b = B_W'(pt_reg.my);
            end
            ST_KE:
            begin
                req.op = OP_DIV;
                req.a  = A_W'(acc_reg);
                req.b  = {pt_reg.rho, 1'b0};
            end
            ST_P:
            begin
                req.a = A_W'(pt_reg.energy - acc_reg[31:0]);
                req.b = B_W'(gamma - GAMMA_ONE);
            end
            ST_GP:
            begin
                req.a = A_W'(p_reg);
                req.b = B_W'(gamma);
            end
            ST_C2:
            begin
                req.op = OP_DIV;
                req.a  = A_W'(acc_reg);
                req.b  = B_W'(pt_reg.rho);
            end
            ST_SQ:
            begin
                req.op = OP_SQRT;
                req.a  = A_W'(acc_reg) << FRAC_BITS;
            end
            ST_SX:
            begin
                req.a = A_W'(vx_reg) + A_W'(c_reg);
                req.b = B_W'(time_step);
            end
            ST_CX:
            begin
                req.a = A_W'(t_reg);
                req.b = B_W'(pt_reg.inv_dx);
            end
            ST_SY:
            begin
                req.a = A_W'(vy_reg) + A_W'(c_reg);
                req.b = B_W'(time_step);
            end
            ST_CY:
            begin
                req.a = A_W'(t_reg);
                req.b = B_W'(pt_reg.inv_dy);
            end
            default:
            begin
                req.op = OP_MUL;
            end
        endcase
    end

    // point payload and intermediate results
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pt_reg <= q_data;
        end
        if (resp.done)
        begin
            case (step_reg)
                ST_VX:   vx_reg  <= resp.res[V_W-1:0];
                ST_VY:   vy_reg  <= resp.res[V_W-1:0];
                ST_MX2:  acc_reg <= resp.res[63:0];
                ST_MY2:  acc_reg <= acc_reg + resp.res[63:0];
                ST_KE:   acc_reg <= resp.res[63:0];
                ST_P:    p_reg   <= p_now;
                ST_GP:   acc_reg <= resp.res[63:0];
                ST_C2:   acc_reg <= resp.res[63:0];
                ST_SX:   t_reg   <= resp.res[SPD_W+31:32];
                ST_SY:   t_reg   <= resp.res[SPD_W+31:32];
                default: t_reg   <= t_reg;
            endcase
        end
    end

    // sequencer, reduction and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            launched_reg  <= 1'b0;
            c_reg         <= '0;
            max_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_max_reg   <= '0;
            out_flag_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_max_reg   <= max_reg;
                out_flag_reg  <= flag_reg;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (req.start)
            begin
                launched_reg <= 1'b1;
            end
            if (resp.done)
            begin
                launched_reg <= 1'b0;
            end
            case (step_reg)
                ST_IDLE:
                begin
                    if (q_stat.valid)
                    begin
                        step_reg <= ST_VX;
                    end
                end
                ST_KE:
                begin
                    if (resp.done)
                    begin
                        if (good)
                        begin
                            step_reg <= ST_P;
                        end
                        else
                        begin
                            flag_reg <= 1'b1;
                            c_reg    <= '0;
                            step_reg <= ST_SX;
                        end
                    end
                end
                ST_P:
                begin
                    if (resp.done)
                    begin
                        if (p_now != '0)
                        begin
                            step_reg <= ST_GP;
                        end
                        else
                        begin
                            flag_reg <= 1'b1;
                            c_reg    <= '0;
                            step_reg <= ST_SX;
                        end
                    end
                end
                ST_SQ:
                begin
                    if (resp.done)
                    begin
                        c_reg    <= resp.res[ROOT_W-1:0];
                        step_reg <= ST_SX;
                    end
                end
                ST_CX, ST_CY:
                begin
                    if (resp.done)
                    begin
                        if (cfl_now > max_reg)
                        begin
                            max_reg <= cfl_now;
                        end
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ST_DONE:
                begin
                    if (!pt_reg.last)
                    begin
                        step_reg <= ST_IDLE;
                    end
                    else if (emit)
                    begin
                        max_reg  <= '0;
                        flag_reg <= 1'b0;
                        step_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    if (resp.done)
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
            endcase
        end
    end

endmodule

// File: rtl/euler2d_max_cfl_reduce.sv
`timescale 1ns / 1ps

// Maximum CFL number over a sweep of a 2-D ideal-gas grid.
// Input stream (s_axis): one grid point per request, tlast marks the
// final point of a sweep. Output stream (m_axis): one request per sweep,
// sent after the point with tlast, carrying the saturated maximum CFL
// in tdata and the non-positive pressure flag in tuser.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 = gamma (Q3.16,
// low 19 bits of cfg_data), 1 = time step (Q0.32); cfg_ready is always high.
// A point is handled by one shared iterative unit (shift-add multiply,
// restoring divide, digit-by-digit square root, one bit per cycle); when
// the energy test fails or the pressure rounds to zero, the sound speed
// is zero and its steps are skipped. After the last point's arithmetic,
// the sweep result enters the output register once free. A two-entry
// queue lets up to two points be taken while the arithmetic is busy.
// Reset clears the running maximum, the flag, the queue and the output
// register, and loads gamma = 1.4 and time step = 0.
// When the receiver stalls, the result stays in the output register and
// points keep being processed until the next sweep ends, then wait for it.
module euler2d_max_cfl_reduce
    import cfl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // density, momentum_x, momentum_y, total_energy, inv_dx, inv_dy
    input  logic [191:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // max_cfl
    output logic [31:0]  m_axis_tdata,
    // nonphysical_seen
    output logic         m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [18:0] gamma_reg;
    logic [31:0] dt_reg;
    q_stat_t     q_stat;
    logic        push;
    logic        pop;
    point_t      pt_in;
    point_t      pt_out;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RESET;
            dt_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAMMA: gamma_reg <= cfg_data[18:0];
                REG_DT:    dt_reg    <= cfg_data;
                default:   dt_reg    <= dt_reg;
            endcase
        end
    end

    cfl_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_stat        (q_stat),
        .push          (push),
        .pt            (pt_in)
    );

    cfl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (pt_in),
        .pop     (pop),
        .rd_data (pt_out),
        .q_stat  (q_stat)
    );

    cfl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_data        (pt_out),
        .pop           (pop),
        .gamma         (gamma_reg),
        .time_step     (dt_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // a full queue refuses points
    assert property (@(posedge clk) disable iff (!rst_n) q_stat.full |-> !s_axis_tready)
        else $error("point accepted into a full queue");

    // the back end only takes points that are there
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_stat.valid)
        else $error("pop from an empty queue");

    // a pop without a push from a queue that is not full leaves it not full
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && !q_stat.full) |=> !q_stat.full)
        else $error("queue count out of step");

endmodule

// File: bench/euler2d_max_cfl_reduce_tb.sv
`timescale 1ns / 1ps

module euler2d_max_cfl_reduce_tb;
    import cfl_pkg::*;

    typedef struct {
        logic [31:0] rho;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] energy;
        logic [31:0] inv_dx;
        logic [31:0] inv_dy;
        logic        last;
    } grid_point_t;

    typedef struct {
        logic [31:0] max_cfl;
        logic        bad_p;
    } sweep_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [31:0]  cfg_data;

    euler2d_max_cfl_reduce uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    grid_point_t   point_q[$];
    sweep_result_t sweep_q[$];

    // predictor state
    logic [18:0] gamma_m;
    logic [31:0] dt_m;
    logic [31:0] run_max;
    logic        run_bad;

    int  errors;
    int  n_points;
    int  n_sweeps;
    int  n_flagged;
    bit  point_taken;
    bit  result_taken;
    bit  cfg_taken;
    int  hold_reqs;
    bit  burst_mode;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #80_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [127:0] isqrt(logic [127:0] v);
        logic [127:0] root;
        logic [127:0] trial;
        root = '0;
        for (int i = 36; i >= 0; i--)
        begin
            trial = root | (128'd1 << i);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [31:0] dir_cfl(logic [127:0] speed, logic [31:0] inv_d);
        logic [127:0] t;
        logic [127:0] prod;
        t = (speed * dt_m) >> 32;
        prod = (t * inv_d) >> FRAC_BITS;
        return (prod > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    endfunction

    // per-point cfl and sweep accumulation
    task automatic accumulate_point(grid_point_t p);
        logic [127:0] rho, amx, amy, vx, vy, ke, pr, c2, c, one;
        logic [31:0]  cx, cy;
        bit           bad;
        sweep_result_t r;
        one = 128'd1 << FRAC_BITS;
        rho = (p.rho == 0) ? 128'd1 : 128'(p.rho);
        amx = p.mx[31] ? 128'(33'h1_0000_0000 - p.mx) : 128'(p.mx);
        amy = p.my[31] ? 128'(33'h1_0000_0000 - p.my) : 128'(p.my);
        vx = (amx << FRAC_BITS) / rho;
        vy = (amy << FRAC_BITS) / rho;
        ke = (amx * amx + amy * amy) / (2 * rho);
        c = 0;
        bad = 1'b1;
        if (128'(p.energy) > ke && 128'(gamma_m) > one)
        begin
            pr = ((128'(gamma_m) - one) * (128'(p.energy) - ke)) >> FRAC_BITS;
            if (pr != 0)
            begin
                c2 = (128'(gamma_m) * pr) / rho;
                c = isqrt(c2 << FRAC_BITS);
                bad = 1'b0;
            end
        end
        if (bad)
            run_bad = 1'b1;
        cx = dir_cfl(vx + c, p.inv_dx);
        cy = dir_cfl(vy + c, p.inv_dy);
        if (cx > run_max)
            run_max = cx;
        if (cy > run_max)
            run_max = cy;
        if (p.last)
        begin
            r.max_cfl = run_max;
            r.bad_p = run_bad;
            sweep_q.push_back(r);
            run_max = '0;
            run_bad = 1'b0;
        end
    endtask

    // monitor: config, point and result requests
    always @(posedge clk)
    begin
        grid_point_t   p;
        sweep_result_t e;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GAMMA)
                    gamma_m = cfg_data[18:0];
                else
                    dt_m = cfg_data;
                cfg_taken = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                p.rho = s_axis_tdata[31:0];
                p.mx = s_axis_tdata[63:32];
                p.my = s_axis_tdata[95:64];
                p.energy = s_axis_tdata[127:96];
                p.inv_dx = s_axis_tdata[159:128];
                p.inv_dy = s_axis_tdata[191:160];
                p.last = s_axis_tlast;
                accumulate_point(p);
                n_points++;
                point_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_taken = 1'b1;
                if (sweep_q.size() == 0)
                begin
                    $error("unexpected result max_cfl=%h nonphysical_seen=%b",
                           m_axis_tdata, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    e = sweep_q.pop_front();
                    n_sweeps++;
                    if (e.bad_p)
                        n_flagged++;
                    if (m_axis_tdata !== e.max_cfl)
                    begin
                        $error("max_cfl expected %h actual %h", e.max_cfl, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser !== e.bad_p)
                    begin
                        $error("nonphysical_seen expected %b actual %b",
                               e.bad_p, m_axis_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    // driver: point requests with random gaps
    int gap_left;
    always @(negedge clk)
    begin
        grid_point_t p;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end
        else if (s_axis_tvalid && !point_taken)
        begin
            s_axis_tvalid <= 1'b1;
        end
        else
        begin
            point_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (point_q.size() > 0)
            begin
                p = point_q.pop_front();
                s_axis_tdata <= {p.inv_dy, p.inv_dx, p.energy, p.my, p.mx, p.rho};
                s_axis_tlast <= p.last;
                s_axis_tvalid <= 1'b1;
                gap_left = burst_mode ? 0 : $urandom_range(0, 13);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    int stall_left;
    int long_left;
    int holds_seen;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            long_left = 0;
            holds_seen = 0;
        end
        else
        begin
            if (hold_reqs != holds_seen)
            begin
                holds_seen = hold_reqs;
                long_left = 4000;
            end
            if (result_taken)
            begin
                result_taken = 1'b0;
                stall_left = burst_mode ? 0 : $urandom_range(0, 13);
            end
            if (long_left > 0)
            begin
                long_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge clk);
        cfg_taken = 1'b0;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_point(logic [31:0] rho, logic [31:0] mx, logic [31:0] my,
                             logic [31:0] en, logic [31:0] idx, logic [31:0] idy,
                             logic last);
        grid_point_t p;
        p.rho = rho;
        p.mx = mx;
        p.my = my;
        p.energy = en;
        p.inv_dx = idx;
        p.inv_dy = idy;
        p.last = last;
        point_q.push_back(p);
    endtask

    function automatic logic [31:0] rand_mom(int k);
        logic [31:0] m;
        m = $urandom_range(0, (1 << k) - 1);
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    // random sweeps, mostly physical states with some raw noise
    task automatic add_sweeps(int n_items, int max_len);
        int left;
        int len;
        logic [31:0] rho;
        left = n_items;
        while (left > 0)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 30)
                                               : $urandom_range(1, max_len);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    add_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              i == len - 1);
                else
                begin
                    rho = $urandom_range(1 << 12, 1 << 24);
                    add_point(rho, rand_mom($urandom_range(8, 24)),
                              rand_mom($urandom_range(8, 24)), $urandom,
                              $urandom_range(0, 1 << $urandom_range(10, 31)),
                              $urandom_range(0, 1 << $urandom_range(10, 31)),
                              i == len - 1);
                end
            end
            left -= len;
        end
    endtask

    task automatic wait_idle();
        wait (point_q.size() == 0 && !s_axis_tvalid && sweep_q.size() == 0);
        repeat (1500) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_GAMMA;
        cfg_data = '0;
        gamma_m = GAMMA_RESET;
        dt_m = '0;
        run_max = '0;
        run_bad = 1'b0;
        errors = 0;
        n_points = 0;
        n_sweeps = 0;
        n_flagged = 0;
        hold_reqs = 0;
        burst_mode = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: dt is zero so every cfl is zero
        add_point(32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0010_0000,
                  32'h0001_0000, 32'h0001_0000, 1'b1);
        wait_idle();

        write_reg(REG_DT, 32'h4000_0000);
        // zero density, max density, momentum extremes
        add_point(32'h0, 32'h0000_0100, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000,
                  32'h0001_0000, 1'b0);
        add_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_point(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000,
                  32'h0, 1'b1);
        // non-positive pressure, zero spacings, single-point and longer sweeps
        add_point(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        add_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0008_0000,
                  32'h0002_0000, 32'h0, 1'b0);
        add_point(32'h0002_0000, 32'h0, 32'hFFFE_0000, 32'h0010_0000, 32'h0,
                  32'h0004_0000, 1'b0);
        add_point(32'h0000_8000, 32'h0, 32'h0, 32'h0000_0001, 32'h0001_0000,
                  32'h0001_0000, 1'b1);
        wait_idle();

        // saturation: max dt, huge velocity and inverse spacing
        write_reg(REG_DT, 32'hFFFF_FFFF);
        write_reg(REG_GAMMA, 32'h0004_0000);
        add_point(32'h0000_0001, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 1'b1);
        add_point(32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h0000_0001, 1'b1);
        // gamma of exactly one gives no pressure
        wait_idle();
        write_reg(REG_GAMMA, 32'h0001_0000);
        add_point(32'h0001_0000, 32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000,
                  32'h0001_0000, 1'b1);
        add_point(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                  32'h0001_0000, 1'b1);
        add_sweeps(150, 6);
        wait_idle();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_GAMMA, 32'(GAMMA_RESET)); write_reg(REG_DT, 32'h0100_0000); end
                1: begin write_reg(REG_GAMMA, 32'h0004_0000); write_reg(REG_DT, 32'hFFFF_FFFF); end
                2: begin write_reg(REG_GAMMA, 32'hFFFF_FFFF); write_reg(REG_DT, 32'h0000_0001); end
                default:
                begin
                    write_reg(REG_GAMMA, $urandom_range(32'h1_0000, 32'h4_0000));
                    write_reg(REG_DT, $urandom);
                end
            endcase
            burst_mode = (ph == 4);
            if (ph == 3)
            begin
                // receiver holds off while short sweeps keep arriving
                hold_reqs++;
                add_sweeps(20, 1);
            end
            add_sweeps(270, 8);
            wait_idle();
        end

        $display("checked %0d grid points in %0d sweeps, %0d with non-positive pressure",
                 n_points, n_sweeps, n_flagged);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
